// ===== rtl/ovea_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the output VC allocator with escape VC and credits.
// Depends on nothing; every other file of the block imports it.
package ovea_pkg;

   // Default sizes of the output port.
   localparam int NUM_VNETS_DEF      = 4;
   localparam int VC_PER_VNET_DEF    = 4;
   localparam int BUFFERS_PER_VC_DEF = 4;

   // Global VC index inside the block: vnet (2 bits) times up to 8 VCs per vnet.
   localparam int VC_IDX_W = 5;

   // Request codes.
   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_PROBE  = 2'd1;
   localparam logic [1:0] REQ_SENT   = 2'd2;
   localparam logic [1:0] REQ_CREDIT = 2'd3;

   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] vnet;
      logic [3:0] in_vc;
      logic       is_head;
      logic       updn_here;
      logic [3:0] credit_vc;
      logic       free_signal;
   } req_item_type;

   typedef struct packed {
      logic       granted;
      logic [3:0] granted_vc;
      logic       escape_claimed;
      logic [2:0] free_vc_count;
      logic       credit_available;
      logic       credit_error;
   } rsp_item_type;

   // State changes caused by one request.
   typedef struct packed {
      logic                alloc_set;
      logic [VC_IDX_W-1:0] alloc_idx;
      logic                free_clr;
      logic [VC_IDX_W-1:0] free_idx;
      logic                cred_inc;
      logic                cred_dec;
      logic [3:0]          cred_idx;
   } state_update_type;

endpackage

// ===== rtl/ovea_vc_state.sv =====
`timescale 1ns / 1ps
// Busy flags of all output VCs and credit counters of the first 16, updated once per request.
// Depends on ovea_pkg.
module ovea_vc_state
   import ovea_pkg::*;
#(
   parameter int NUM_VNETS      = NUM_VNETS_DEF,
   parameter int VC_PER_VNET    = VC_PER_VNET_DEF,
   parameter int BUFFERS_PER_VC = BUFFERS_PER_VC_DEF,
   localparam int EFF_VNETS     = (NUM_VNETS < 4) ? NUM_VNETS : 4,
   localparam int BUSY_DEPTH    = EFF_VNETS * VC_PER_VNET,
   localparam int NUM_VCS       = NUM_VNETS * VC_PER_VNET,
   localparam int CRED_DEPTH    = (NUM_VCS < 16) ? NUM_VCS : 16,
   localparam int CRED_W        = $clog2(BUFFERS_PER_VC + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  apply,
   input  state_update_type      upd,
   input  logic [3:0]            credit_vc,
   output logic [BUSY_DEPTH-1:0] busy,
   output logic [CRED_W-1:0]     cred_rd
);

   logic [BUSY_DEPTH-1:0] busy_ff, busy_in;
   logic [CRED_W-1:0]     cred_ff [CRED_DEPTH];
   logic [CRED_W-1:0]     cred_in [CRED_DEPTH];

   always_comb begin
      busy_in = busy_ff;
      for (int i = 0; i < BUSY_DEPTH; i++) begin
         if (upd.alloc_set && upd.alloc_idx == VC_IDX_W'(i)) begin
            busy_in[i] = 1'b1;
         end
         if (upd.free_clr && upd.free_idx == VC_IDX_W'(i)) begin
            busy_in[i] = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CRED_DEPTH; i++) begin
         cred_in[i] = cred_ff[i];
         if (upd.cred_idx == 4'(i)) begin
            if (upd.cred_inc) begin
               cred_in[i] = cred_ff[i] + CRED_W'(1);
            end else if (upd.cred_dec) begin
               cred_in[i] = cred_ff[i] - CRED_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         for (int i = 0; i < CRED_DEPTH; i++) begin
            cred_ff[i] <= CRED_W'(BUFFERS_PER_VC);
         end
      end else if (apply) begin
         busy_ff <= busy_in;
         for (int i = 0; i < CRED_DEPTH; i++) begin
            cred_ff[i] <= cred_in[i];
         end
      end
   end

   // Read port for the credit VC of the pending request; out of range reads zero.
   always_comb begin
      cred_rd = '0;
      for (int i = 0; i < CRED_DEPTH; i++) begin
         if (credit_vc == 4'(i)) begin
            cred_rd = cred_ff[i];
         end
      end
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/ovea_alloc_logic.sv =====
`timescale 1ns / 1ps
// Single-pass decision logic: VC grant under the escape rules, idle count, credit check.
// Depends on ovea_pkg; reads the state held in ovea_vc_state.
module ovea_alloc_logic
   import ovea_pkg::*;
#(
   parameter int NUM_VNETS      = NUM_VNETS_DEF,
   parameter int VC_PER_VNET    = VC_PER_VNET_DEF,
   parameter int BUFFERS_PER_VC = BUFFERS_PER_VC_DEF,
   localparam int EFF_VNETS     = (NUM_VNETS < 4) ? NUM_VNETS : 4,
   localparam int BUSY_DEPTH    = EFF_VNETS * VC_PER_VNET,
   localparam int NUM_VCS       = NUM_VNETS * VC_PER_VNET,
   localparam int CRED_DEPTH    = (NUM_VCS < 16) ? NUM_VCS : 16,
   localparam int CRED_W        = $clog2(BUFFERS_PER_VC + 1)
) (
   input  req_item_type          item,
   input  logic                  escape_enable,
   input  logic [BUSY_DEPTH-1:0] busy,
   input  logic [CRED_W-1:0]     cred_cur,
   output rsp_item_type          rsp,
   output state_update_type      upd
);

   localparam int KW = (VC_PER_VNET > 1) ? $clog2(VC_PER_VNET) : 1;
   localparam logic [KW-1:0] ESC_K = KW'(VC_PER_VNET - 1);
   localparam logic [VC_PER_VNET-1:0] ESC_BIT = (VC_PER_VNET)'(1) << (VC_PER_VNET - 1);

   logic [VC_PER_VNET-1:0] vnet_busy [4];
   logic [VC_PER_VNET-1:0] idle;
   logic [KW:0]            pick_all, pick_reg;
   logic                   vnet_ok, cvc_ok, cvc_in_busy, in_on_esc;
   logic [VC_IDX_W-1:0]    gbase, gidx;
   logic                   grant_ok, claimed;
   logic [KW-1:0]          grant_k;
   logic [3:0]             idle_cnt;
   logic                   cred_zero, cred_full;
   logic                   is_grant_req;

   // Busy flags of each vnet; vnets without VCs look fully busy.
   for (genvar vn = 0; vn < 4; vn++) begin : g_slice
      if (vn < EFF_VNETS) begin : g_real
         assign vnet_busy[vn] = busy[vn*VC_PER_VNET +: VC_PER_VNET];
      end else begin : g_none
         assign vnet_busy[vn] = '1;
      end
   end

   // Lowest set bit: {found, index}.
   function automatic logic [KW:0] lowest(input logic [VC_PER_VNET-1:0] m);
      logic [KW:0] r;
      r = '0;
      for (int k = VC_PER_VNET - 1; k >= 0; k--) begin
         if (m[k]) begin
            r = {1'b1, KW'(k)};
         end
      end
      return r;
   endfunction

   assign vnet_ok      = (3'(item.vnet) < 3'(EFF_VNETS));
   assign idle         = ~vnet_busy[item.vnet];
   assign pick_all     = lowest(idle);
   assign pick_reg     = lowest(idle & ~ESC_BIT);
   assign gbase        = VC_IDX_W'(item.vnet) * VC_IDX_W'(VC_PER_VNET);
   assign in_on_esc    = ({1'b0, item.in_vc} == (gbase + VC_IDX_W'(VC_PER_VNET - 1)));
   assign is_grant_req = (item.req_type == REQ_ALLOC) || (item.req_type == REQ_PROBE);

   always_comb begin
      grant_ok = 1'b0;
      grant_k  = '0;
      claimed  = 1'b0;
      if (is_grant_req && vnet_ok) begin
         priority if (!escape_enable) begin
            {grant_ok, grant_k} = pick_all;
         end else if (in_on_esc) begin
            grant_ok = idle[VC_PER_VNET-1];
            grant_k  = ESC_K;
         end else if (item.is_head) begin
            if (item.updn_here) begin
               {grant_ok, grant_k} = pick_all;
               claimed = grant_ok && (grant_k == ESC_K);
            end else begin
               {grant_ok, grant_k} = pick_reg;
            end
         end
      end
   end

   assign gidx     = gbase + VC_IDX_W'(grant_k);
   assign idle_cnt = vnet_ok ? 4'($countones(idle)) : 4'd0;

   assign cvc_ok      = (5'(item.credit_vc) < 5'(CRED_DEPTH));
   assign cvc_in_busy = (6'(item.credit_vc) < 6'(BUSY_DEPTH));
   assign cred_zero   = (cred_cur == '0);
   assign cred_full   = (cred_cur >= CRED_W'(BUFFERS_PER_VC));

   always_comb begin
      rsp.granted          = grant_ok;
      rsp.granted_vc       = grant_ok ? gidx[3:0] : 4'd0;
      rsp.escape_claimed   = claimed;
      rsp.free_vc_count    = (idle_cnt > 4'd7) ? 3'd7 : idle_cnt[2:0];
      rsp.credit_available = 1'b0;
      rsp.credit_error     = 1'b0;

      upd.alloc_set = (item.req_type == REQ_ALLOC) && grant_ok;
      upd.alloc_idx = gidx;
      upd.free_clr  = 1'b0;
      upd.free_idx  = VC_IDX_W'(item.credit_vc);
      upd.cred_inc  = 1'b0;
      upd.cred_dec  = 1'b0;
      upd.cred_idx  = item.credit_vc;

      unique case (item.req_type)
         REQ_ALLOC, REQ_PROBE: begin
            rsp.credit_available = cvc_ok && !cred_zero;
         end
         REQ_SENT: begin
            if (cvc_ok) begin
               rsp.credit_error     = cred_zero;
               upd.cred_dec         = !cred_zero;
               rsp.credit_available = (cred_cur > CRED_W'(1));
            end
         end
         REQ_CREDIT: begin
            if (cvc_ok) begin
               rsp.credit_error     = cred_full;
               upd.cred_inc         = !cred_full;
               rsp.credit_available = 1'b1;
               upd.free_clr         = item.free_signal && cvc_in_busy;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/output_vc_allocator_escape_credit_top.sv =====
`timescale 1ns / 1ps
// Top level of the output VC allocator with escape VC and credit tracking.
// Depends on ovea_pkg, ovea_vc_state and ovea_alloc_logic.
//
// Usage:
//   req_*  : request channel (valid/stall). A request is taken at a rising edge
//            with req_valid high and req_stall low. Codes: allocate, probe,
//            flit sent, credit returned.
//   rsp_*  : result channel (valid/stall), one result per request, in order.
//   csr_*  : write channel for escape_enable (csr_ready is always high). Write
//            it only while no request is in flight.
// Path: input register, decision logic, result register, then rsp_*.
// Throughput: one request per cycle unless rsp_stall holds a result. The input
//   register and the result register each hold one request; the decision is one
//   pass of logic between them and the VC state is updated as the result is
//   registered, so the next request already sees it.
// Reset: every VC idle, every credit count at BUFFERS_PER_VC, escape off,
//   both registers empty.
// Stall: while rsp_stall holds a result, the result register holds and the
//   input register keeps one more request; then req_stall rises.
module output_vc_allocator_escape_credit_top
   import ovea_pkg::*;
#(
   parameter int NUM_VNETS      = NUM_VNETS_DEF,
   parameter int VC_PER_VNET    = VC_PER_VNET_DEF,
   parameter int BUFFERS_PER_VC = BUFFERS_PER_VC_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_wdata
);

   localparam int EFF_VNETS  = (NUM_VNETS < 4) ? NUM_VNETS : 4;
   localparam int BUSY_DEPTH = EFF_VNETS * VC_PER_VNET;
   localparam int CRED_W     = $clog2(BUFFERS_PER_VC + 1);

   logic                  escape_ff;
   logic                  in_valid_ff, in_valid_in;
   req_item_type          in_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_data_ff;
   logic                  out_free, advance, take;
   logic [BUSY_DEPTH-1:0] busy;
   logic [CRED_W-1:0]     cred_rd;
   rsp_item_type          rsp_next;
   state_update_type      upd;

   // Configuration: always ready; the user must write it only while idle, the block does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else if (csr_valid) begin
         escape_ff <= csr_wdata;
      end
   end

   // Result register can load when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   // Input register: hold a request until the result register takes it.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_data;
      end
   end

   ovea_vc_state #(
      .NUM_VNETS      (NUM_VNETS),
      .VC_PER_VNET    (VC_PER_VNET),
      .BUFFERS_PER_VC (BUFFERS_PER_VC)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .apply     (advance),
      .upd       (upd),
      .credit_vc (in_item_ff.credit_vc),
      .busy      (busy),
      .cred_rd   (cred_rd)
   );

   ovea_alloc_logic #(
      .NUM_VNETS      (NUM_VNETS),
      .VC_PER_VNET    (VC_PER_VNET),
      .BUFFERS_PER_VC (BUFFERS_PER_VC)
   ) u_logic (
      .item          (in_item_ff),
      .escape_enable (escape_ff),
      .busy          (busy),
      .cred_cur      (cred_rd),
      .rsp           (rsp_next),
      .upd           (upd)
   );

   // Result register: load on advance, drop once taken, hold while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/ovea_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the output VC allocator, bound to the top level.
// Depends on ovea_pkg and output_vc_allocator_escape_credit_top.
module ovea_checker
   import ovea_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result changed");

   // No grant means no VC index and no escape claim.
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |->
         rsp_data.granted_vc == 4'd0 && !rsp_data.escape_claimed)
      else $error("VC or escape claim reported without grant");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind output_vc_allocator_escape_credit_top ovea_checker u_checker (.*);

// ===== tb/output_vc_allocator_escape_credit_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the output VC allocator with escape VC and credits.
// Depends on ovea_pkg and output_vc_allocator_escape_credit_top; needs nothing else.
module output_vc_allocator_escape_credit_top_tb;
   import ovea_pkg::*;

   localparam int VC_TOTAL       = NUM_VNETS_DEF * VC_PER_VNET_DEF;
   // Give up after this many cycles in which no request, result or write moves.
   localparam int STUCK_LIMIT    = 4000;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_PER_RUN = 610;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_wdata = 1'b0;

   // Shadow of the output port: escape mode, VC busy flags and credit counts.
   bit           escape_mode;
   bit           vc_taken [VC_TOTAL];
   int           vc_credit_count [VC_TOTAL];

   rsp_item_type pending_decisions [$];
   int           send_idle_pct;
   int           recv_stall_pct;
   int           mismatch_count;
   int           stuck_cycles;

   output_vc_allocator_escape_credit_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Lowest idle VC in [lo, hi), or -1 when all of them are taken.
   function automatic int lowest_idle_vc(input int lo, input int hi);
      for (int v = lo; v < hi; v++) begin
         if (v >= 0 && v < VC_TOTAL && !vc_taken[v]) return v;
      end
      return -1;
   endfunction

   // Work out the port's answer to one request and advance the shadow state.
   function automatic rsp_item_type decide_output_vc(input req_item_type r);
      rsp_item_type res;
      int           base;
      int           esc;
      int           grant;
      int           cvc;
      int           idle_count;
      bit           vnet_ok;
      bit           cvc_ok;
      bit           err;
      bit           claimed;
      res        = '0;
      base       = int'(r.vnet) * VC_PER_VNET_DEF;
      esc        = base + VC_PER_VNET_DEF - 1;
      grant      = -1;
      cvc        = int'(r.credit_vc);
      idle_count = 0;
      vnet_ok    = int'(r.vnet) < NUM_VNETS_DEF;
      cvc_ok     = cvc < VC_TOTAL;
      err        = 1'b0;
      claimed    = 1'b0;

      // Count before this request touches the busy flags.
      if (vnet_ok) begin
         for (int v = base; v < base + VC_PER_VNET_DEF; v++) begin
            if (!vc_taken[v]) idle_count++;
         end
      end
      if (idle_count > 7) idle_count = 7;

      if ((r.req_type == REQ_ALLOC || r.req_type == REQ_PROBE) && vnet_ok) begin
         if (!escape_mode) begin
            grant = lowest_idle_vc(base, base + VC_PER_VNET_DEF);
         end else if (int'(r.in_vc) == esc) begin
            // Already on the escape VC: stay there or get nothing.
            if (!vc_taken[esc]) grant = esc;
         end else if (r.is_head) begin
            if (r.updn_here) begin
               grant   = lowest_idle_vc(base, base + VC_PER_VNET_DEF);
               claimed = (grant == esc);
            end else begin
               grant = lowest_idle_vc(base, esc);
            end
         end
         if (r.req_type == REQ_ALLOC && grant >= 0) vc_taken[grant] = 1'b1;
      end else if (r.req_type == REQ_SENT && cvc_ok) begin
         if (vc_credit_count[cvc] == 0) err = 1'b1;
         else vc_credit_count[cvc]--;
      end else if (r.req_type == REQ_CREDIT && cvc_ok) begin
         if (vc_credit_count[cvc] >= BUFFERS_PER_VC_DEF) err = 1'b1;
         else vc_credit_count[cvc]++;
         if (r.free_signal) vc_taken[cvc] = 1'b0;
      end

      res.granted          = (grant >= 0);
      res.granted_vc       = (grant >= 0) ? 4'(grant) : 4'd0;
      res.escape_claimed   = claimed;
      res.free_vc_count    = 3'(idle_count);
      res.credit_available = cvc_ok && vc_credit_count[cvc] > 0;
      res.credit_error     = err;
      return res;
   endfunction

   function automatic req_item_type build_request(input logic [1:0] kind,
                                                  input logic [1:0] vnet,
                                                  input logic [3:0] in_vc,
                                                  input logic head, input logic here,
                                                  input logic [3:0] cvc,
                                                  input logic free_sig);
      req_item_type r;
      r.req_type    = kind;
      r.vnet        = vnet;
      r.in_vc       = in_vc;
      r.is_head     = head;
      r.updn_here   = here;
      r.credit_vc   = cvc;
      r.free_signal = free_sig;
      return r;
   endfunction

   // Mix of allocations, probes, flits sent and credits returned. Bias in_vc
   // toward the vnet's escape VC so the stay-on-escape path is hit often.
   function automatic req_item_type random_request();
      req_item_type r;
      int           pick;
      pick          = $urandom_range(99);
      r.req_type    = (pick < 30) ? REQ_ALLOC  :
                      (pick < 45) ? REQ_PROBE  :
                      (pick < 72) ? REQ_SENT   : REQ_CREDIT;
      r.vnet        = 2'($urandom_range(3));
      if ($urandom_range(99) < 30)
         r.in_vc = 4'(int'(r.vnet) * VC_PER_VNET_DEF + VC_PER_VNET_DEF - 1);
      else
         r.in_vc = 4'($urandom_range(15));
      r.is_head     = 1'($urandom_range(1));
      r.updn_here   = 1'($urandom_range(1));
      r.credit_vc   = 4'($urandom_range(15));
      r.free_signal = 1'($urandom_range(1));
      return r;
   endfunction

   // Offer one request, idling first at random, and record its expected answer
   // at the edge that takes it.
   task automatic issue_request(input req_item_type item);
      rsp_item_type expected;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      expected          = decide_output_vc(item);
      pending_decisions = {pending_decisions, expected};
   endtask

   // Drain every outstanding request, then write escape_enable.
   task automatic write_escape_enable(input bit value);
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      escape_mode = value;
   endtask

   // Escape off (reset value): probe vnet 0, fill it in order, then ask once more.
   task automatic test_plain_allocation();
      issue_request(build_request(REQ_PROBE, 2'd0, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0));
      repeat (5)
         issue_request(build_request(REQ_ALLOC, 2'd0, 4'd0, 1'b0, 1'b0, 4'd0, 1'b0));
   endtask

   // Run VC 15 dry and past empty, then refill it and past full with a free.
   task automatic test_credit_limits();
      repeat (5)
         issue_request(build_request(REQ_SENT, 2'd3, 4'd15, 1'b1, 1'b1, 4'd15, 1'b1));
      for (int i = 0; i < 5; i++)
         issue_request(build_request(REQ_CREDIT, 2'd3, 4'd0, 1'b0, 1'b0, 4'd15,
                                     1'(i % 2 == 0 || i == 4)));
   endtask

   // Escape on, vnet 2 (VCs 8..11, escape VC 11).
   task automatic test_escape_rules();
      write_escape_enable(1'b1);
      // Body flit off the escape VC: nothing.
      issue_request(build_request(REQ_ALLOC, 2'd2, 4'd15, 1'b0, 1'b1, 4'd0, 1'b0));
      // Head without up-down: regular VC only.
      issue_request(build_request(REQ_ALLOC, 2'd2, 4'd0, 1'b1, 1'b0, 4'd8, 1'b0));
      // Flit on the escape VC: probe it without taking it.
      issue_request(build_request(REQ_PROBE, 2'd2, 4'd11, 1'b0, 1'b0, 4'd11, 1'b0));
      // Head with up-down: lowest idle, then the escape VC with a claim.
      repeat (3)
         issue_request(build_request(REQ_ALLOC, 2'd2, 4'd3, 1'b1, 1'b1, 4'd9, 1'b0));
      issue_request(build_request(REQ_ALLOC, 2'd2, 4'd3, 1'b1, 1'b0, 4'd9, 1'b0));
      issue_request(build_request(REQ_ALLOC, 2'd2, 4'd11, 1'b1, 1'b0, 4'd11, 1'b0));
      // Credit at full with free: error, yet the escape VC comes back idle.
      issue_request(build_request(REQ_CREDIT, 2'd2, 4'd0, 1'b0, 1'b0, 4'd11, 1'b1));
   endtask

   // One idling profile: half the traffic with escape off, half with it on.
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      write_escape_enable(1'b0);
      repeat (RANDOM_PER_RUN / 2) issue_request(random_request());
      write_escape_enable(1'b1);
      repeat (RANDOM_PER_RUN - RANDOM_PER_RUN / 2) issue_request(random_request());
   endtask

   // Compare one result from the port against the oldest expected answer.
   task automatic check_decision(input rsp_item_type got);
      rsp_item_type want;
      if (pending_decisions.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with no request outstanding: %p", $realtime, got);
      end else begin
         want = pending_decisions.pop_front();
         if (got.granted          !== want.granted          ||
             got.granted_vc       !== want.granted_vc       ||
             got.escape_claimed   !== want.escape_claimed   ||
             got.free_vc_count    !== want.free_vc_count    ||
             got.credit_available !== want.credit_available ||
             got.credit_error     !== want.credit_error) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: mismatch expected %p got %p", $realtime, want, got);
         end
      end
   endtask

   // Take results, stalling the result channel at the current rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_decision(rsp_data);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: count cycles in which nothing moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      escape_mode    = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      stuck_cycles   = 0;
      for (int v = 0; v < VC_TOTAL; v++) begin
         vc_taken[v]        = 1'b0;
         vc_credit_count[v] = BUFFERS_PER_VC_DEF;
      end

      // Hold reset from the start, then release it once for the whole run.
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_allocation();
      test_credit_limits();
      test_escape_rules();
      test_random_traffic(24, 50);
      test_random_traffic(50, 24);
      test_random_traffic(0, 0);

      // Drop valid, drain what is in flight, and let the pipeline settle.
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== output_vc_allocator_escape_credit_top.f =====
rtl/ovea_pkg.sv
rtl/ovea_vc_state.sv
rtl/ovea_alloc_logic.sv
rtl/output_vc_allocator_escape_credit_top.sv
rtl/ovea_checker.sv
tb/output_vc_allocator_escape_credit_top_tb.sv
